[sv/tcw_pkg.sv]
// Shared constants, payload types and control structs of the text console writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int IDX_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CELL_W    = 16;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS);

    localparam logic [2:0] MODE_PUT   = 3'd0;
    localparam logic [2:0] MODE_SET   = 3'd1;
    localparam logic [2:0] MODE_MOVE  = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PINK  = 2'd2;

    localparam logic [7:0] ATTR_WHITE_RST = 8'd15;
    localparam logic [7:0] ATTR_RED_RST   = 8'd12;
    localparam logic [7:0] ATTR_PINK_RST  = 8'd13;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;

    typedef struct packed {
        logic [2:0]        mode;
        logic [7:0]        ch;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [IDX_W-1:0]  cell_index;
    } t_in;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       cur_attr;
        logic             wrote;
        logic [IDX_W-1:0] wrote_index;
        logic [7:0]       read_char;
        logic [7:0]       read_attr;
    } t_out;

    typedef struct packed {
        logic take;
        logic fin_now;
        logic fin_read;
        logic clr_step;
        logic fin_clear;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic need_read;
        logic need_clear;
        logic clr_last;
    } t_stat;

endpackage

[sv/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tcw_ctrl.sv]
// Controller state machine: sequences ops that finish from the idle state, cell reads and screen clears.
module tcw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.need_read) begin
                        n_state = ST_READ;
                    end else if (i_stat.need_clear) begin
                        n_state = ST_CLEAR;
                    end else begin
                        o_cmd.fin_now = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.fin_read = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin_clear = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/tcw_dpath.sv]
// Datapath: cursor, attribute and escape state, config registers, screen RAM, result register.
module tcw_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tcw_pkg::t_cmd                   i_cmd,
    output tcw_pkg::t_stat                  o_stat,
    input  tcw_pkg::t_in                    i_in_data,
    input  logic                            i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tcw_pkg::t_out                   o_out_data
);

    localparam int SUM_W = 10;

    logic [tcw_pkg::COL_W-1:0] r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0] r_row, n_row;
    logic [7:0]                r_attr, n_attr;
    logic                      r_esc, n_esc;
    logic [7:0]                r_white, r_red, r_pink;
    logic [tcw_pkg::IDX_W-1:0] r_clr_cnt, n_clr_cnt;
    tcw_pkg::t_in              r_item;
    logic                      r_rd_ok;
    tcw_pkg::t_out             r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                        ram_we;
    logic [tcw_pkg::IDX_W-1:0]   ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

    logic                      is_put, put_byte, put_clear, put_wr, is_nl, wrap;
    logic [tcw_pkg::ROW_W-1:0] row_adv;
    logic [tcw_pkg::COL_W-1:0] col_adv;
    logic [tcw_pkg::IDX_W-1:0] widx;
    logic [7:0]                esc_attr;

    function automatic logic [tcw_pkg::COL_W-1:0] clamp_col(input logic signed [SUM_W-1:0] v);
        logic [tcw_pkg::COL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SUM_W'(tcw_pkg::COLUMNS)) begin
            res = tcw_pkg::COL_MAX;
        end else begin
            res = v[tcw_pkg::COL_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [tcw_pkg::ROW_W-1:0] clamp_row(input logic signed [SUM_W-1:0] v);
        logic [tcw_pkg::ROW_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SUM_W'(tcw_pkg::ROWS)) begin
            res = tcw_pkg::ROW_MAX;
        end else begin
            res = v[tcw_pkg::ROW_W-1:0];
        end
        return res;
    endfunction

    // Decode of the offered item against the current cursor
    assign is_put    = (i_in_data.mode == tcw_pkg::MODE_PUT);
    assign is_nl     = (i_in_data.ch == tcw_pkg::CH_LF);
    assign put_byte  = is_put && !r_esc && (i_in_data.ch != tcw_pkg::CH_CARET)
                       && (i_in_data.ch != tcw_pkg::CH_NUL);
    assign wrap      = is_nl || (r_col >= tcw_pkg::COL_MAX);
    assign row_adv   = (wrap && (r_row < tcw_pkg::ROW_MAX)) ? r_row + tcw_pkg::ROW_W'(1) : r_row;
    assign col_adv   = wrap ? '0 : r_col;
    assign put_clear = put_byte && (row_adv >= tcw_pkg::ROW_MAX);
    assign put_wr    = put_byte && !put_clear && !is_nl;
    assign widx      = tcw_pkg::IDX_W'(int'(row_adv) * tcw_pkg::COLUMNS + int'(col_adv));

    always_comb begin
        case (i_in_data.ch)
            tcw_pkg::CH_W: esc_attr = r_white;
            tcw_pkg::CH_R: esc_attr = r_red;
            tcw_pkg::CH_P: esc_attr = r_pink;
            default:       esc_attr = r_attr;
        endcase
    end

    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.need_read  = (i_in_data.mode == tcw_pkg::MODE_READ);
    assign o_stat.need_clear = (i_in_data.mode == tcw_pkg::MODE_CLEAR) || put_clear;
    assign o_stat.clr_last   = (r_clr_cnt == tcw_pkg::IDX_W'(tcw_pkg::CELLS - 1));

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_attr      = r_attr;
        n_esc       = r_esc;
        n_clr_cnt   = r_clr_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;

        if (i_cmd.take) begin
            n_clr_cnt = '0;
        end

        if (i_cmd.fin_now) begin
            case (i_in_data.mode)
                tcw_pkg::MODE_PUT: begin
                    if (r_esc) begin
                        n_esc  = 1'b0;
                        n_attr = esc_attr;
                    end else if (i_in_data.ch == tcw_pkg::CH_CARET) begin
                        n_esc = 1'b1;
                    end else if (put_byte) begin
                        n_row = row_adv;
                        n_col = is_nl ? '0 : col_adv + tcw_pkg::COL_W'(1);
                    end
                end
                tcw_pkg::MODE_SET: begin
                    n_col = clamp_col(SUM_W'(i_in_data.pos_x));
                    n_row = clamp_row(SUM_W'(i_in_data.pos_y));
                end
                tcw_pkg::MODE_MOVE: begin
                    n_col = clamp_col($signed({3'b000, r_col}) + SUM_W'(i_in_data.pos_x));
                    n_row = clamp_row($signed({5'b00000, r_row}) + SUM_W'(i_in_data.pos_y));
                end
                default: begin
                end
            endcase
            if (put_wr) begin
                ram_we    = 1'b1;
                ram_waddr = widx;
                ram_wdata = {i_in_data.ch, r_attr};
            end
            n_out.cursor_col  = n_col;
            n_out.cursor_row  = n_row;
            n_out.cur_attr    = n_attr;
            n_out.wrote       = put_wr;
            n_out.wrote_index = put_wr ? widx : '0;
            n_out.read_char   = '0;
            n_out.read_attr   = '0;
            n_out_valid       = 1'b1;
        end

        if (i_cmd.fin_read) begin
            n_out.cursor_col  = r_col;
            n_out.cursor_row  = r_row;
            n_out.cur_attr    = r_attr;
            n_out.wrote       = 1'b0;
            n_out.wrote_index = '0;
            n_out.read_char   = r_rd_ok ? ram_rdata[15:8] : '0;
            n_out.read_attr   = r_rd_ok ? ram_rdata[7:0] : '0;
            n_out_valid       = 1'b1;
        end

        // Sweep one cell per cycle with blanks in the white attribute
        if (i_cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = {tcw_pkg::CH_SPACE, r_white};
            n_clr_cnt = r_clr_cnt + tcw_pkg::IDX_W'(1);
        end

        // After a wrap-driven clear, the byte that caused it lands at the home cell unless it is a newline
        if (i_cmd.fin_clear) begin
            n_col             = '0;
            n_row             = '0;
            n_out.wrote       = 1'b0;
            if ((r_item.mode == tcw_pkg::MODE_PUT) && (r_item.ch != tcw_pkg::CH_LF)) begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = {r_item.ch, r_attr};
                n_col       = tcw_pkg::COL_W'(1);
                n_out.wrote = 1'b1;
            end
            n_out.cursor_col  = n_col;
            n_out.cursor_row  = n_row;
            n_out.cur_attr    = r_attr;
            n_out.wrote_index = '0;
            n_out.read_char   = '0;
            n_out.read_attr   = '0;
            n_out_valid       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= tcw_pkg::ATTR_WHITE_RST;
            r_esc       <= 1'b0;
            r_white     <= tcw_pkg::ATTR_WHITE_RST;
            r_red       <= tcw_pkg::ATTR_RED_RST;
            r_pink      <= tcw_pkg::ATTR_PINK_RST;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_attr      <= n_attr;
            r_esc       <= n_esc;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcw_pkg::CFG_WHITE: r_white <= i_cfg_data;
                    tcw_pkg::CFG_RED:   r_red   <= i_cfg_data;
                    tcw_pkg::CFG_PINK:  r_pink  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.take) begin
            r_item  <= i_in_data;
            r_rd_ok <= (i_in_data.cell_index < tcw_pkg::IDX_W'(tcw_pkg::CELLS));
        end
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.take),
        .i_raddr (i_in_data.cell_index),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/text_console_writer_core.sv]
// Top level of the text console writer: controller plus datapath.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid / o_in_stall  i_in_data (tcw_pkg::t_in)
//   out      output     o_out_valid / i_out_stall o_out_data (tcw_pkg::t_out)
//   cfg      input      i_cfg_we                i_cfg_index, i_cfg_data
//
// Put, set, move and unused modes finish from the idle state; a new transaction can follow next cycle unless
// the output stalls. A cell read passes through the registered read of the screen RAM, then the result register.
// A clear, or a put that runs past the last row, sweeps all CELLS cells: the sweep
// writes one cell per cycle through the single RAM write port.
// Synchronous active-low reset returns cursor, attribute, escape and config to their defaults; screen is not swept.
// Input stalls while a multicycle transaction runs or while a held result is stalled downstream.
module text_console_writer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tcw_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tcw_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    tcw_pkg::t_cmd  cmd;
    tcw_pkg::t_stat stat;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcw_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[sv/tcw_checker.sv]
// Port-level assertions for the text console writer, bound to the top level.
module tcw_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input tcw_pkg::t_out o_out_data
);

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cursor_col <= tcw_pkg::COL_MAX)
                        && (o_out_data.cursor_row <= tcw_pkg::ROW_MAX))
        else $error("cursor beyond screen bounds");

    a_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.wrote |->
            (o_out_data.wrote_index < tcw_pkg::IDX_W'(tcw_pkg::CELLS))
            && (o_out_data.read_char == 8'd0) && (o_out_data.read_attr == 8'd0)
            && (o_out_data.cursor_col != '0))
        else $error("inconsistent write report");

    a_no_write_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.wrote |-> (o_out_data.wrote_index == '0))
        else $error("write index without a write");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

[tb/text_console_writer_core_tb.sv]
// Self-checking testbench for the text console writer core, driven by tasks with a scoreboard class.
module text_console_writer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 320;
    localparam int TAIL_CYCLES  = 16;
    localparam int ITEM_BOUND   = PHASES * PHASE_ITEMS + 200;
    // Worst case per transaction: a full clear sweep, a full sender gap and a full output stall.
    localparam int LIMIT        = 4 * ITEM_BOUND * (CELLS + 2 + 2 * 9 + 8);

    // Shadow of the console: cursor, attribute, escape state and both screen planes.
    class console_tracker;
        logic [7:0] white;
        logic [7:0] red;
        logic [7:0] pink;
        logic [7:0] attr;
        bit         esc;
        int         col;
        int         row;
        logic [7:0] chars [CELLS];
        logic [7:0] attrs [CELLS];
        bit         known [CELLS];
        int         last_index;
        t_out       expected_views [$];
        int         n_checked;
        int         errors;
        int         n_writes;
        int         n_reads;
        int         n_clears;

        function new();
            white = ATTR_WHITE_RST;
            red   = ATTR_RED_RST;
            pink  = ATTR_PINK_RST;
            attr  = ATTR_WHITE_RST;
            esc   = 1'b0;
            col   = 0;
            row   = 0;
            last_index = 0;
            foreach (chars[i]) begin
                chars[i] = '0;
                attrs[i] = '0;
                known[i] = 1'b0;
            end
        endfunction

        function void set_palette(logic [7:0] w, logic [7:0] r, logic [7:0] p);
            white = w;
            red   = r;
            pink  = p;
        endfunction

        function int clamp(int v, int hi);
            if (v > hi) v = hi;
            if (v < 0) v = 0;
            return v;
        endfunction

        function void wipe();
            foreach (chars[i]) begin
                chars[i] = CH_SPACE;
                attrs[i] = white;
                known[i] = 1'b1;
            end
            col = 0;
            row = 0;
            n_clears++;
        endfunction

        function void note_request(t_in req);
            t_out v;
            int   x;
            int   y;
            v = '0;
            x = int'(req.pos_x);
            y = int'(req.pos_y);
            case (req.mode)
                MODE_PUT: begin
                    if (esc) begin
                        esc = 1'b0;
                        if (req.ch == CH_W) attr = white;
                        else if (req.ch == CH_R) attr = red;
                        else if (req.ch == CH_P) attr = pink;
                    end else if (req.ch == CH_CARET) begin
                        esc = 1'b1;
                    end else if (req.ch != CH_NUL) begin
                        // Wrap on newline or on a put past the last column.
                        if (req.ch == CH_LF || col >= COLUMNS) begin
                            col = 0;
                            if (row < ROWS) row++;
                        end
                        if (row >= ROWS) wipe();
                        if (req.ch != CH_LF) begin
                            x = row * COLUMNS + col;
                            chars[x] = req.ch;
                            attrs[x] = attr;
                            known[x] = 1'b1;
                            last_index = x;
                            if (col < COLUMNS) col++;
                            v.wrote       = 1'b1;
                            v.wrote_index = IDX_W'(x);
                            n_writes++;
                        end
                    end
                end
                MODE_SET: begin
                    col = clamp(x, COLUMNS);
                    row = clamp(y, ROWS);
                end
                MODE_MOVE: begin
                    col = clamp(col + x, COLUMNS);
                    row = clamp(row + y, ROWS);
                end
                MODE_READ: begin
                    if (req.cell_index < CELLS) begin
                        v.read_char = chars[req.cell_index];
                        v.read_attr = attrs[req.cell_index];
                        n_reads++;
                    end
                end
                MODE_CLEAR: wipe();
                default: ;
            endcase
            v.cursor_col = COL_W'(col);
            v.cursor_row = ROW_W'(row);
            v.cur_attr   = attr;
            expected_views.push_back(v);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_view(t_out got);
            t_out want;
            if (expected_views.size() == 0) begin
                $error("result transaction with no request waiting");
                errors++;
                return;
            end
            want = expected_views.pop_front();
            n_checked++;
            check_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
            check_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            check_field("cur_attr", 16'(want.cur_attr), 16'(got.cur_attr));
            check_field("wrote", 16'(want.wrote), 16'(got.wrote));
            check_field("wrote_index", 16'(want.wrote_index), 16'(got.wrote_index));
            check_field("read_char", 16'(want.read_char), 16'(got.read_char));
            check_field("read_attr", 16'(want.read_attr), 16'(got.read_attr));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WHITE;
    logic [7:0]           cfg_data  = '0;

    console_tracker sb = new();
    int             n_sent   = 0;
    int             cycles   = 0;
    int             palettes = 0;
    bit             calm     = 1'b0;

    text_console_writer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sample both channels at the same edge so ordering against the driver never matters.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
        if (rst_n && out_valid && !out_stall) sb.check_view(out_data);
    end

    initial begin
        @(posedge clk);
        forever begin
            if (calm) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 60 : 15)) @(posedge clk);
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_in base_req(input logic [2:0] mode);
        t_in r;
        r.mode       = mode;
        r.ch         = 8'($urandom);
        r.pos_x      = 8'($urandom);
        r.pos_y      = 8'($urandom);
        r.cell_index = IDX_W'($urandom);
        return r;
    endfunction

    // Hold the transaction until accepted; lower valid only when a gap follows.
    task automatic send(input t_in req);
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic send_put(input logic [7:0] ch);
        t_in r;
        r    = base_req(MODE_PUT);
        r.ch = ch;
        send(r);
    endtask

    task automatic send_cursor(input logic [2:0] mode, input int x, input int y);
        t_in r;
        r       = base_req(mode);
        r.pos_x = 8'(x);
        r.pos_y = 8'(y);
        send(r);
    endtask

    task automatic send_read(input int idx);
        t_in r;
        r            = base_req(MODE_READ);
        r.cell_index = IDX_W'(idx);
        send(r);
    endtask

    task automatic send_mode(input logic [2:0] mode);
        send(base_req(mode));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.n_checked < n_sent) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic load_palette(input logic [7:0] w, input logic [7:0] r, input logic [7:0] p);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WHITE;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_RED;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= CFG_PINK;
        cfg_data  <= p;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_palette(w, r, p);
        palettes++;
    endtask

    task automatic run_directed();
        send_put(8'h41);
        send_read(0);
        send_put(CH_CARET);
        send_put(CH_R);
        send_put(8'hFF);
        send_put(CH_CARET);
        send_put(CH_P);
        send_put(8'h01);
        // Escape followed by an unknown letter, a second caret and a NUL: all consumed.
        send_put(CH_CARET);
        send_put(8'h78);
        send_put(CH_CARET);
        send_put(CH_CARET);
        send_put(CH_CARET);
        send_put(CH_NUL);
        send_put(CH_NUL);
        send_put(CH_CARET);
        send_put(CH_W);
        send_put(CH_LF);
        send_cursor(MODE_SET, 127, 127);
        send_cursor(MODE_MOVE, -128, -128);
        send_cursor(MODE_MOVE, 127, 127);
        // A put from the last row past the last column wraps, clears and lands at home.
        send_cursor(MODE_SET, COLUMNS, ROWS - 1);
        send_put(8'h43);
        send_read(CELLS - 1);
        send_read(2 ** IDX_W - 1);
        send_mode(MODE_SPARE_FIRST);
        send_mode(MODE_CLEAR);
    endtask

    task automatic run_traffic(input int n);
        int done;
        int r;
        int x;
        int y;
        int idx;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if ($urandom_range(0, 7) == 0) send_put(8'($urandom));
                else send_put(8'($urandom_range(8'h21, 8'h7E)));
            end else if (r < 60) begin
                send_put(CH_CARET);
                case ($urandom_range(0, 4))
                    0: send_put(CH_W);
                    1: send_put(CH_R);
                    2: send_put(CH_P);
                    3: send_put(8'($urandom_range(8'h61, 8'h7A)));
                    default: send_put(8'($urandom));
                endcase
                done++;
            end else if (r < 65) begin
                send_put(CH_LF);
            end else if (r < 73) begin
                x = $urandom_range(0, 86) - 3;
                y = $urandom_range(0, 28) - 2;
                if ($urandom_range(0, 7) == 0) begin
                    x = $urandom_range(0, 255);
                    y = $urandom_range(0, 255);
                end
                send_cursor(MODE_SET, x, y);
            end else if (r < 81) begin
                x = $urandom_range(0, 16) - 8;
                y = $urandom_range(0, 6) - 3;
                if ($urandom_range(0, 7) == 0) begin
                    x = $urandom_range(0, 255);
                    y = $urandom_range(0, 255);
                end
                send_cursor(MODE_MOVE, x, y);
            end else if (r < 93) begin
                idx = ($urandom_range(0, 1) == 0) ? sb.last_index : $urandom_range(0, CELLS - 1);
                if ($urandom_range(0, 31) == 0) idx = $urandom_range(CELLS, 2 ** IDX_W - 1);
                // Never read a cell that has not been written or cleared.
                if (idx < CELLS && !sb.known[idx]) send_put(CH_SPACE);
                else send_read(idx);
            end else if (r < 95) begin
                send_put(CH_NUL);
            end else if (r < 98) begin
                send_mode(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)));
            end else begin
                send_mode(MODE_CLEAR);
            end
            done++;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_palette(8'h00, 8'hFF, 8'h00);
                1: load_palette(8'hFF, 8'h00, 8'hFF);
                PHASES - 1: load_palette(8'h80, 8'h7F, 8'h01);
                default: load_palette(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            if (ph == PHASES - 1) calm = 1'b1;
            run_traffic(PHASE_ITEMS);
            drain();
        end

        if (sb.expected_views.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_views.size());
            sb.errors++;
        end
        $display("Ran %0d requests over %0d palettes in %0d cycles", n_sent, palettes, cycles);
        $display("Saw %0d cell writes, %0d cell reads and %0d screen clears",
                 sb.n_writes, sb.n_reads, sb.n_clears);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
